@@ src/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths, register indexes and helpers for the socket distance pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  localparam int COORD_W = 32;               // input coordinate width
  localparam int REG_W   = 31;               // configuration register width
  localparam int IDX_W   = 8;                // configuration index width
  localparam int CFG_W   = 32;               // configuration data width
  localparam int NUM_REGS = 8;
  localparam int REG_AW  = $clog2(NUM_REGS); // register file address width

  localparam int WORK_W  = 36;               // signed internal coordinate width
  localparam int ROOT_W  = 36;               // floor root width
  localparam int SUM_W   = 2 * ROOT_W;       // sum of squares width
  localparam int NORM_W  = ROOT_W + 1;       // rounded root width
  localparam int HALF_W  = WORK_W / 2;       // partial product operand width
  localparam int NORM_LAT = ROOT_W + 3;      // squares, sum, root bits, rounding

  localparam int DIFF_W  = NORM_W + 1;       // norm minus a size
  localparam int DIST_W  = DIFF_W + 1;       // inner term plus outer norm
  localparam int FIN_W   = DIST_W + 1;       // after negation

  localparam logic signed [COORD_W-1:0] CUP_X_POS_DEF = '0;
  localparam logic signed [COORD_W-1:0] CUP_Z_POS_DEF = '0;

  typedef enum logic [IDX_W-1:0] {
    REG_BOX_HALF_X    = 8'd0,
    REG_BOX_HALF_Y    = 8'd1,
    REG_BOX_HALF_Z    = 8'd2,
    REG_CUP_HALF_H    = 8'd3,
    REG_CUP_RADIUS    = 8'd4,
    REG_HOLE_RADIUS   = 8'd5,
    REG_HOLE_HALF_H   = 8'd6,
    REG_HOLE_OFFSET   = 8'd7
  } reg_idx_t;

  function automatic logic [WORK_W-1:0] mag(input logic signed [WORK_W-1:0] v);
    mag = v[WORK_W-1] ? WORK_W'(-v) : WORK_W'(v);
  endfunction

  function automatic logic [WORK_W-1:0] posv(input logic signed [WORK_W-1:0] v);
    posv = v[WORK_W-1] ? '0 : WORK_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ src/socket_shape_distance.sv @@
// ----------------------------------------------------------------------------
// socket_shape_distance
// Signed distance from a point to a box with a cup and two holes cut out.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata: point_x, point_y, point_z
//  m_*       out        tdata: signed_distance; tuser: saturated
//  cfg_*     in         index, data (register write)
//
//  One point enters per cycle while the pipe is not stalled; the path runs through
//  the two bit-per-stage square root pipes in series.
//  The whole pipe advances when the output register is empty or taken.
//  Reset clears valid bits and the configuration registers to zero.
//  Configuration writes are always accepted.
`default_nettype none

module socket_shape_distance #(
  parameter logic signed [31:0] CUP_X_POS = ssd_pkg::CUP_X_POS_DEF,
  parameter logic signed [31:0] CUP_Z_POS = ssd_pkg::CUP_Z_POS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [3*ssd_pkg::COORD_W-1:0] s_tdata,  // point_x, point_y, point_z
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [ssd_pkg::COORD_W-1:0]      m_tdata,    // signed_distance
  output logic                             m_tuser,    // saturated
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ssd_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [ssd_pkg::CFG_W-1:0]   cfg_data
);
  import ssd_pkg::*;

  logic [REG_W-1:0] regs [NUM_REGS];
  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (cfg_valid && (cfg_index < IDX_W'(NUM_REGS))) begin
      regs[cfg_index[REG_AW-1:0]] <= cfg_data[REG_W-1:0];
    end
  end

  logic signed [WORK_W-1:0] bhx, bhy, bhz, ch, cr, hr, hh, ho;
  assign bhx = WORK_W'(regs[REG_AW'(REG_BOX_HALF_X)]);
  assign bhy = WORK_W'(regs[REG_AW'(REG_BOX_HALF_Y)]);
  assign bhz = WORK_W'(regs[REG_AW'(REG_BOX_HALF_Z)]);
  assign ch  = WORK_W'(regs[REG_AW'(REG_CUP_HALF_H)]);
  assign cr  = WORK_W'(regs[REG_AW'(REG_CUP_RADIUS)]);
  assign hr  = WORK_W'(regs[REG_AW'(REG_HOLE_RADIUS)]);
  assign hh  = WORK_W'(regs[REG_AW'(REG_HOLE_HALF_H)]);
  assign ho  = WORK_W'(regs[REG_AW'(REG_HOLE_OFFSET)]);

  // stage 1: offsets, magnitudes and box terms
  logic signed [WORK_W-1:0] px, py, pz, rx, ry, rz, qx, qy, qz, qmax;
  assign px = WORK_W'($signed(s_tdata[COORD_W-1:0]));
  assign py = WORK_W'($signed(s_tdata[2*COORD_W-1:COORD_W]));
  assign pz = WORK_W'($signed(s_tdata[3*COORD_W-1:2*COORD_W]));
  assign rx = px - WORK_W'(CUP_X_POS);
  assign ry = py - bhy;
  assign rz = pz - WORK_W'(CUP_Z_POS);
  assign qx = $signed(mag(px)) - bhx;
  assign qy = $signed(mag(py)) - bhy;
  assign qz = $signed(mag(pz)) - bhz;
  assign qmax = (qx > qy) ? ((qx > qz) ? qx : qz) : ((qy > qz) ? qy : qz);

  logic                     v1;
  logic [WORK_W-1:0]        ax, az0, az1, az2, ycup, yhole, bpx, bpy, bpz;
  logic signed [WORK_W-1:0] boxmin;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax     <= mag(rx);
      az0    <= mag(rz);
      az1    <= mag(rz + ho);
      az2    <= mag(rz - ho);
      ycup   <= mag(ry);
      yhole  <= mag(ry + ch);
      bpx    <= posv(qx);
      bpy    <= posv(qy);
      bpz    <= posv(qz);
      boxmin <= qmax[WORK_W-1] ? qmax : '0;
    end
  end

  // first norms: radial terms and the box outer term
  logic              nv_c, nv_a, nv_b, nv_x;
  logic [NORM_W-1:0] n_cup, n_ha, n_hb, n_box;

  ssd_norm u_norm_cup (.clk, .rst, .en, .in_valid(v1), .a(ax), .b(az0), .c('0),
                       .out_valid(nv_c), .root(n_cup));
  ssd_norm u_norm_ha  (.clk, .rst, .en, .in_valid(v1), .a(ax), .b(az1), .c('0),
                       .out_valid(nv_a), .root(n_ha));
  ssd_norm u_norm_hb  (.clk, .rst, .en, .in_valid(v1), .a(ax), .b(az2), .c('0),
                       .out_valid(nv_b), .root(n_hb));
  ssd_norm u_norm_box (.clk, .rst, .en, .in_valid(v1), .a(bpx), .b(bpy), .c(bpz),
                       .out_valid(nv_x), .root(n_box));

  logic [3*WORK_W-1:0] side1;
  logic [WORK_W-1:0]   ycup_d, yhole_d;
  logic signed [WORK_W-1:0] boxmin_d;

  ssd_delay #(.WIDTH(3*WORK_W), .DEPTH(NORM_LAT)) u_delay_a (
    .clk, .en, .din({ycup, yhole, boxmin}), .dout(side1)
  );
  assign ycup_d   = side1[3*WORK_W-1:2*WORK_W];
  assign yhole_d  = side1[2*WORK_W-1:WORK_W];
  assign boxmin_d = $signed(side1[WORK_W-1:0]);

  // stage 2: cylinder radial and axial offsets, inner terms and box distance
  logic signed [DIFF_W-1:0] d0c, d0a, d0b, d1c, d1h;
  assign d0c = $signed({1'b0, n_cup}) - DIFF_W'(cr);
  assign d0a = $signed({1'b0, n_ha})  - DIFF_W'(hr);
  assign d0b = $signed({1'b0, n_hb})  - DIFF_W'(hr);
  assign d1c = DIFF_W'($signed({1'b0, ycup_d}))  - DIFF_W'(ch);
  assign d1h = DIFF_W'($signed({1'b0, yhole_d})) - DIFF_W'(hh);

  function automatic logic signed [DIFF_W-1:0] inner(
    input logic signed [DIFF_W-1:0] p, input logic signed [DIFF_W-1:0] q);
    logic signed [DIFF_W-1:0] m;
    m = (p > q) ? p : q;
    inner = m[DIFF_W-1] ? m : '0;
  endfunction

  function automatic logic [WORK_W-1:0] clip(input logic signed [DIFF_W-1:0] v);
    clip = v[DIFF_W-1] ? '0 : v[WORK_W-1:0];
  endfunction

  logic                     v2;
  logic signed [DIFF_W-1:0] in_c, in_a, in_b;
  logic [WORK_W-1:0]        p0c, p0a, p0b, p1c, p1h;
  logic signed [DIST_W-1:0] boxd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= nv_c & nv_a & nv_b & nv_x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_c <= inner(d0c, d1c);
      in_a <= inner(d0a, d1h);
      in_b <= inner(d0b, d1h);
      p0c  <= clip(d0c);
      p0a  <= clip(d0a);
      p0b  <= clip(d0b);
      p1c  <= clip(d1c);
      p1h  <= clip(d1h);
      boxd <= $signed({2'b00, n_box}) + DIST_W'(boxmin_d);
    end
  end

  // second norms: outer distance of each cylinder
  logic              mv_c, mv_a, mv_b;
  logic [NORM_W-1:0] o_cup, o_ha, o_hb;

  ssd_norm u_outer_cup (.clk, .rst, .en, .in_valid(v2), .a(p0c), .b(p1c), .c('0),
                        .out_valid(mv_c), .root(o_cup));
  ssd_norm u_outer_ha  (.clk, .rst, .en, .in_valid(v2), .a(p0a), .b(p1h), .c('0),
                        .out_valid(mv_a), .root(o_ha));
  ssd_norm u_outer_hb  (.clk, .rst, .en, .in_valid(v2), .a(p0b), .b(p1h), .c('0),
                        .out_valid(mv_b), .root(o_hb));

  localparam int SIDE2_W = 3 * DIFF_W + DIST_W;
  logic [SIDE2_W-1:0] side2;
  logic signed [DIFF_W-1:0] in_c_d, in_a_d, in_b_d;
  logic signed [DIST_W-1:0] boxd_d;

  ssd_delay #(.WIDTH(SIDE2_W), .DEPTH(NORM_LAT)) u_delay_b (
    .clk, .en, .din({in_c, in_a, in_b, boxd}), .dout(side2)
  );
  assign in_c_d = $signed(side2[SIDE2_W-1:2*DIFF_W+DIST_W]);
  assign in_a_d = $signed(side2[2*DIFF_W+DIST_W-1:DIFF_W+DIST_W]);
  assign in_b_d = $signed(side2[DIFF_W+DIST_W-1:DIST_W]);
  assign boxd_d = $signed(side2[DIST_W-1:0]);

  // stage 3: cylinder distances
  logic                     v3;
  logic signed [DIST_W-1:0] cyl_c, cyl_a, cyl_b, boxd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= mv_c & mv_a & mv_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cyl_c <= DIST_W'(in_c_d) + $signed({2'b00, o_cup});
      cyl_a <= DIST_W'(in_a_d) + $signed({2'b00, o_ha});
      cyl_b <= DIST_W'(in_b_d) + $signed({2'b00, o_hb});
      boxd3 <= boxd_d;
    end
  end

  // stage 4: subtract the union, saturate, hold for the consumer
  logic signed [DIST_W-1:0] umin;
  logic signed [FIN_W-1:0]  cut, dres;
  logic                     hi_clip, lo_clip;
  assign umin = (cyl_c < cyl_a) ? ((cyl_c < cyl_b) ? cyl_c : cyl_b)
                                : ((cyl_a < cyl_b) ? cyl_a : cyl_b);
  assign cut  = -FIN_W'(umin);
  assign dres = (FIN_W'(boxd3) > cut) ? FIN_W'(boxd3) : cut;
  assign hi_clip = dres > FIN_W'(33'sh0_7FFF_FFFF);
  assign lo_clip = dres < -FIN_W'(33'sh0_8000_0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= hi_clip ? 32'h7FFF_FFFF : (lo_clip ? 32'h8000_0000 : dres[COORD_W-1:0]);
      m_tuser <= hi_clip | lo_clip;
    end
  end

endmodule

`default_nettype wire

@@ src/ssd_delay.sv @@
// ----------------------------------------------------------------------------
// ssd_delay
// Enabled shift line that carries side data alongside the norm units.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

`default_nettype wire

@@ src/ssd_norm.sv @@
// ----------------------------------------------------------------------------
// ssd_norm
// Pipelined Euclidean norm of three unsigned terms, rounded to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_norm (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [ssd_pkg::WORK_W-1:0] a,
  input  wire logic [ssd_pkg::WORK_W-1:0] b,
  input  wire logic [ssd_pkg::WORK_W-1:0] c,
  output logic                           out_valid,
  output logic [ssd_pkg::NORM_W-1:0]     root
);
  import ssd_pkg::*;

  localparam int EXT_W = SUM_W + 2;

  // partial products: hi*hi, hi*lo, lo*lo for each term
  logic [WORK_W-1:0] pp_hh [3];
  logic [WORK_W-1:0] pp_hl [3];
  logic [WORK_W-1:0] pp_ll [3];
  logic              v_pp;

  logic [WORK_W-1:0] ops [3];
  assign ops[0] = a;
  assign ops[1] = b;
  assign ops[2] = c;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pp_hh[i] <= ops[i][WORK_W-1:HALF_W] * ops[i][WORK_W-1:HALF_W];
        pp_hl[i] <= ops[i][WORK_W-1:HALF_W] * ops[i][HALF_W-1:0];
        pp_ll[i] <= ops[i][HALF_W-1:0] * ops[i][HALF_W-1:0];
      end
    end
  end

  logic [SUM_W-1:0] sq [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = ({pp_hh[i], {WORK_W{1'b0}}})
            + (SUM_W'(pp_hl[i]) << (HALF_W + 1))
            + SUM_W'(pp_ll[i]);
    end
  end

  // root stages: stage 0 holds the radicand
  logic [SUM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic              v_q    [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= sq[0] + sq[1] + sq[2];
      root_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    localparam int K = ROOT_W - 1 - i;
    logic [EXT_W-1:0] trial;
    logic             fits;
    assign trial = ({(EXT_W-ROOT_W-1)'(0), root_q[i], 1'b0} + (EXT_W'(1) << K)) << K;
    assign fits  = trial <= {2'b00, rem_q[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1]  <= fits ? SUM_W'({2'b00, rem_q[i]} - trial) : rem_q[i];
        root_q[i+1] <= fits ? (root_q[i] | (ROOT_W'(1) << K)) : root_q[i];
      end
    end
  end

  // round up when the remainder exceeds the floor root
  always_ff @(posedge clk) begin
    if (en) begin
      root <= {1'b0, root_q[ROOT_W]}
            + NORM_W'(rem_q[ROOT_W] > SUM_W'(root_q[ROOT_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pp      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i <= ROOT_W; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en) begin
      v_pp <= in_valid;
      v_q[0] <= v_pp;
      for (int i = 0; i < ROOT_W; i++) begin
        v_q[i+1] <= v_q[i];
      end
      out_valid <= v_q[ROOT_W];
    end
  end

endmodule

`default_nettype wire
